// File: src/sitda_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
`timescale 1ns / 1ps
`default_nettype none

package sitda_pkg;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_SIGN,
        ST_EMIT
    } sitda_state_t;

endpackage

`default_nettype wire

// File: src/signed_integer_to_decimal_ascii_unit.sv
// Top level: converts a signed integer into its decimal ASCII characters.
//
// Input channel: value with in_valid / in_stall. A beat is taken when in_valid
// is high and in_stall is low. in_stall rises after the accepted beat and stays
// high until the number's final character is loaded into the output register.
// Output channel: character and last with out_valid / out_stall. One beat per
// character, most significant digit first, a leading '-' for negative numbers,
// and last set on the final digit.
// Timing: the magnitude is converted by a shared shift-and-add-3 step, one
// input bit per cycle, over all VALUE_BITS bits. Leading zero digits are then
// dropped at one per cycle, the sequencer then picks the sign or the first
// digit, and the characters go out one per cycle while the receiver does not
// stall.
// The output register lets the final character wait while the next number is
// already accepted.
// Reset clears the sequencer and the output valid; the block comes out of
// reset idle and ready. While the receiver stalls, the output beat holds and
// the sequencer waits to load the next character.
`timescale 1ns / 1ps
`default_nettype none

module signed_integer_to_decimal_ascii_unit #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [VALUE_BITS-1:0] value,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [7:0]                 character,
    output logic                       last
);
    import sitda_pkg::*;

    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_BITS   = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int DIG_W      = $clog2(NUM_DIGITS + 1);

    sitda_state_t          state_reg, state_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BCD_BITS-1:0]   bcd_reg, bcd_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIG_W-1:0]      dig_left_reg, dig_left_next;
    logic                  neg_reg, neg_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            char_reg, char_next;
    logic                  last_reg, last_next;

    logic [BCD_BITS-1:0]   bcd_step;
    logic [VALUE_BITS-1:0] neg_value;
    logic [3:0]            top_digit;
    logic                  slot_free;

    sitda_bcd_step #(
        .DIGITS(NUM_DIGITS)
    ) u_step (
        .bcd        (bcd_reg),
        .in_bit     (mag_reg[VALUE_BITS-1]),
        .bcd_shifted(bcd_step)
    );

    assign neg_value = ~value + 1'b1;
    assign top_digit = bcd_reg[BCD_BITS-1 -: 4];
    assign slot_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        cnt_reg      <= cnt_next;
        dig_left_reg <= dig_left_next;
        neg_reg      <= neg_next;
        char_reg     <= char_next;
        last_reg     <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        dig_left_next  = dig_left_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next      = value[VALUE_BITS-1];
                    mag_next      = value[VALUE_BITS-1] ? neg_value : value;
                    bcd_next      = '0;
                    cnt_next      = CNT_W'(VALUE_BITS - 1);
                    dig_left_next = DIG_W'(NUM_DIGITS);
                    state_next    = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next = bcd_step;
                mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Drop leading zeros, but keep the units digit so zero prints as '0'.
                if (top_digit == 4'd0 && dig_left_reg != DIG_W'(1))
                begin
                    bcd_next      = {bcd_reg[BCD_BITS-5:0], 4'd0};
                    dig_left_next = dig_left_reg - 1'b1;
                end
                else if (neg_reg)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = ASCII_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = ASCII_ZERO + {4'd0, top_digit};
                    last_next      = (dig_left_reg == DIG_W'(1));
                    bcd_next       = {bcd_reg[BCD_BITS-5:0], 4'd0};
                    dig_left_next  = dig_left_reg - 1'b1;
                    if (dig_left_reg == DIG_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// File: src/sitda_bcd_step.sv
// One shift-and-add-3 step of the binary to BCD converter.
`timescale 1ns / 1ps
`default_nettype none

module sitda_bcd_step #(
    parameter int DIGITS = 10
) (
    input  wire logic [4*DIGITS-1:0] bcd,
    input  wire logic                in_bit,
    output logic [4*DIGITS-1:0]      bcd_shifted
);
    import sitda_pkg::*;

    logic [4*DIGITS-1:0] adjusted;

    // Every digit of five or more gets three added, so that the following
    // doubling carries correctly into the next decimal digit.
    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd[4*d +: 4] >= BCD_ADJ_MIN)
            begin
                adjusted[4*d +: 4] = bcd[4*d +: 4] + BCD_ADJ_ADD;
            end
            else
            begin
                adjusted[4*d +: 4] = bcd[4*d +: 4];
            end
        end
    end

    assign bcd_shifted = {adjusted[4*DIGITS-2:0], in_bit};

endmodule

`default_nettype wire

// File: src/sitda_checker.sv
// Port-level checker for the decimal text converter and its bind.
`timescale 1ns / 1ps
`default_nettype none

module sitda_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] character,
    input wire logic       last
);
    import sitda_pkg::*;

    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(character) && $stable(last))
        else $error("output beat changed while stalled");

    // Once a number is taken, the block is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accepted beat");

    // The block frees up only with the final character of the number in place.
    a_free_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid && last)
        else $error("input freed without a final character pending");

    // A minus sign is never the final character, nor followed by another one.
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && character == ASCII_MINUS |->
            !last ##1 !(out_valid && character == ASCII_MINUS))
        else $error("minus sign misplaced");

endmodule

bind signed_integer_to_decimal_ascii_unit sitda_checker u_sitda_checker (.*);

`default_nettype wire

// File: test/tb_top.sv
// Self-checking bench for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0] ch;
    logic       last;
} text_beat_t;

class text_scoreboard;
    text_beat_t pending_chars[$];
    int         fail_count;
    int         shown_count;
    int         numbers_noted;
    int         negatives_noted;
    int         chars_checked;

    function new();
        fail_count      = 0;
        shown_count     = 0;
        numbers_noted   = 0;
        negatives_noted = 0;
        chars_checked   = 0;
    endfunction

    // Works out the decimal text of one accepted number at 32 bits.
    // The magnitude is unsigned, so the most negative value needs no special path.
    function void add_number(logic [31:0] num);
        logic [31:0] mag;
        logic        neg;
        logic [7:0]  digits[$];
        text_beat_t  beat;

        neg = num[31];
        mag = neg ? (~num + 32'd1) : num;
        if (mag == 32'd0) begin
            digits.push_front(sitda_pkg::ASCII_ZERO);
        end
        while (mag != 32'd0) begin
            digits.push_front(sitda_pkg::ASCII_ZERO + 8'(mag % 32'd10));
            mag = mag / 32'd10;
        end
        if (neg) begin
            beat.ch   = sitda_pkg::ASCII_MINUS;
            beat.last = 1'b0;
            pending_chars.push_back(beat);
            negatives_noted++;
        end
        foreach (digits[i]) begin
            beat.ch   = digits[i];
            beat.last = (i == digits.size() - 1);
            pending_chars.push_back(beat);
        end
        numbers_noted++;
    endfunction

    function void check_character(logic [7:0] ch, logic last);
        text_beat_t want;

        if (pending_chars.size() == 0) begin
            fail_count++;
            if (shown_count < 10) begin
                shown_count++;
                $display("Unexpected output beat: character %0d last %0b", ch, last);
            end
            return;
        end
        want = pending_chars.pop_front();
        chars_checked++;
        if (ch !== want.ch || last !== want.last) begin
            fail_count++;
            if (shown_count < 10) begin
                shown_count++;
                $display("Mismatch on character %0d: expected %0d last %0b, got %0d last %0b",
                         chars_checked, want.ch, want.last, ch, last);
            end
        end
    endfunction
endclass

module tb_top;

    import sitda_pkg::*;

    localparam int VALUE_BITS   = 32;
    localparam int RANDOM_ITEMS = 187;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 80;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [VALUE_BITS-1:0] value;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            character;
    logic                  last;
    logic                  hold_off_req;

    text_scoreboard sb = new();

    signed_integer_to_decimal_ascii_unit #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

    always #1 clk = ~clk;

    // Offers one number and waits for its beat; drops valid only if a gap follows.
    task automatic send_value(input logic [VALUE_BITS-1:0] num, input int gap_after);
        in_valid <= 1'b1;
        value    <= num;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.add_number(num);
        if (gap_after > 0) begin
            in_valid <= 1'b0;
            repeat (gap_after) @(posedge clk);
        end
    endtask

    // Receiver: checks every accepted character and stalls on its own pattern.
    initial begin
        int stall_pct;
        int phase_left;
        int hold_left;
        bit hold_done;

        out_stall  = 1'b0;
        stall_pct  = 0;
        phase_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) begin
                sb.check_character(character, last);
            end
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (phase_left == 0) begin
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 30;
                        3:       stall_pct = 60;
                        default: stall_pct = 85;
                    endcase
                    phase_left = $urandom_range(20, 120);
                end
                phase_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial begin
        logic [VALUE_BITS-1:0] directed[];
        logic [VALUE_BITS-1:0] num;
        longint unsigned       lim;
        longint unsigned       mag;
        int                    sent;
        int                    burst_len;
        int                    digit_count;
        int                    waited;

        directed = '{
            32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
            32'd100, -32'sd100, 32'd12345, -32'sd54321, 32'd999999999,
            32'd1000000000, -32'sd1000000000, 32'h7FFF_FFFF, 32'h8000_0001,
            32'h8000_0000, 32'h7FFF_FFFE, 32'd1234567890, -32'sd987654321,
            32'd7, 32'd40
        };
        in_valid     = 1'b0;
        value        = '0;
        hold_off_req = 1'b0;
        rst_n        = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) begin
            send_value(directed[i], (i % 2 == 0) ? 0 : $urandom_range(0, 6));
        end

        // The first random burst runs without gaps while the receiver holds off,
        // so the converter fills up and stalls its input.
        hold_off_req <= 1'b1;
        sent      = 0;
        burst_len = 25;
        while (sent < RANDOM_ITEMS) begin
            for (int b = 0; b < burst_len && sent < RANDOM_ITEMS; b++) begin
                case ($urandom_range(0, 3))
                    0: num = $urandom;
                    1: begin
                        // Edges: around zero and both extremes.
                        case ($urandom_range(0, 2))
                            0:       num = 32'h8000_0000 + $urandom_range(0, 20);
                            1:       num = 32'h7FFF_FFFF - $urandom_range(0, 20);
                            default: num = $urandom_range(0, 40) - 20;
                        endcase
                    end
                    default: begin
                        // A magnitude with a chosen number of digits, either sign; a ten-digit one is cut to 32 bits.
                        digit_count = $urandom_range(1, 10);
                        lim = 1;
                        for (int k = 0; k < digit_count; k++) lim = lim * 10;
                        mag = lim / 10 + ({32'd0, $urandom} % (lim - lim / 10));
                        if (digit_count == 1) mag = {32'd0, $urandom} % 10;
                        num = mag[VALUE_BITS-1:0];
                        if ($urandom_range(0, 1)) num = ~num + 32'd1;
                    end
                endcase
                sent++;
                if (b == burst_len - 1 || sent == RANDOM_ITEMS) begin
                    send_value(num, $urandom_range(0, 8));
                end else begin
                    send_value(num, 0);
                end
            end
            burst_len = $urandom_range(1, 12);
        end
        in_valid <= 1'b0;

        while (sb.pending_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.fail_count > 10) begin
            $display("%0d further mismatches were not shown", sb.fail_count - 10);
        end
        $display("Converted %0d numbers, %0d of them negative, into %0d checked characters.",
                 sb.numbers_noted, sb.negatives_noted, sb.chars_checked);
        $display("Zero, both extremes, every digit count and a long receiver hold-off were run.");
        if (sb.fail_count == 0 && sb.pending_chars.size() == 0) begin
            $display("[signed_integer_to_decimal_ascii_unit] OK");
        end else begin
            $display("[signed_integer_to_decimal_ascii_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("Timeout with %0d characters outstanding", sb.pending_chars.size());
        $display("[signed_integer_to_decimal_ascii_unit] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
src/sitda_pkg.sv
src/sitda_bcd_step.sv
src/signed_integer_to_decimal_ascii_unit.sv
src/sitda_checker.sv
test/tb_top.sv
